FILE: sv/lbc_pkg.sv
package lbc_pkg;

  localparam int KBPS_W = 18;
  localparam int TIME_W = 32;
  localparam int LOSS_W = 15;
  localparam int CNT_W  = 8;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 22;

  typedef logic [KBPS_W-1:0]  kbps_t;
  typedef logic [KBPS_W:0]    kbps_wide_t;
  typedef logic [TIME_W-1:0]  ms_t;
  typedef logic [LOSS_W-1:0]  loss_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // mode codes; the spare code behaves as balanced
  localparam logic [1:0] MODE_BALANCED    = 2'd0;
  localparam logic [1:0] MODE_QUALITY     = 2'd1;
  localparam logic [1:0] MODE_LOW_LATENCY = 2'd2;
  localparam logic [1:0] MODE_SPARE       = 2'd3;

  // register word index
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_INITIAL = 1'b1;

  localparam kbps_t BITRATE_CAP  = 18'd150000;
  localparam kbps_t KBPS_MAX     = 18'h3FFFF;
  localparam kbps_t INITIAL_RST  = 18'd20000;
  localparam kbps_t LO_RST       = 18'd6000;
  localparam kbps_t HI_RST       = 18'd40000;
  localparam kbps_t MIN_BALANCED = 18'd3000;
  localparam kbps_t MIN_QUALITY  = 18'd5000;
  localparam kbps_t MIN_LOW_LAT  = 18'd2000;

  localparam ms_t COOLDOWN_LOW_LAT = 32'd1500;
  localparam ms_t COOLDOWN_DEFAULT = 32'd2000;

  localparam loss_t LOSS_HEAVY  = 15'd1280;
  localparam loss_t LOSS_MEDIUM = 15'd512;
  localparam loss_t LOSS_LIGHT  = 15'd128;

  localparam cnt_t RUN_MEDIUM       = 8'd2;
  localparam cnt_t RUN_LIGHT        = 8'd4;
  localparam cnt_t STABLE_QUALITY   = 8'd3;
  localparam cnt_t STABLE_DEFAULT   = 8'd5;
  localparam cnt_t CNT_MAX          = 8'd255;

  // ceil(f * 2^22 / d): exact floor(x*f/d) for any 18-bit x
  localparam recip_t RECIP_7_10  = 23'd2936013;
  localparam recip_t RECIP_9_10  = 23'd3774874;
  localparam recip_t RECIP_19_20 = 23'd3984589;
  localparam recip_t RECIP_21_20 = 23'd4404020;
  localparam recip_t RECIP_3_10  = 23'd1258292;
  localparam recip_t RECIP_6_5   = 23'd5033165;

  typedef struct packed {
    kbps_t lo;
    kbps_t hi;
  } limits_t;

  typedef struct packed {
    logic  wr;
    kbps_t kbps;
  } reload_t;

  typedef struct packed {
    kbps_t current;
    ms_t   last_change;
    cnt_t  stable;
    cnt_t  loss_run;
  } state_t;

  typedef struct packed {
    kbps_t bitrate;
    logic  changed;
    logic  in_cooldown;
  } result_t;

  function automatic kbps_wide_t scale(input kbps_t x, input recip_t m);
    logic [KBPS_W+RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, x} * {{KBPS_W{1'b0}}, m};
    return p[KBPS_W+RECIP_W-1:RECIP_SHIFT];
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? CNT_MAX : v + 8'd1;
  endfunction

endpackage

FILE: sv/lbc_cfg_regs.sv
module lbc_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [1:0]      mode,
  output lbc_pkg::limits_t limits,
  output lbc_pkg::reload_t reload
);
  import lbc_pkg::*;

  kbps_t      initial_kbps;
  limits_t    limits_next;
  kbps_wide_t hi_wide;
  kbps_wide_t lo_wide;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BALANCED;
      initial_kbps <= INITIAL_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MODE:    mode         <= pwdata[1:0];
        REG_INITIAL: initial_kbps <= pwdata[KBPS_W-1:0];
        default: ;
      endcase
    end
  end

  // a write of the initial rate reloads the running rate
  assign reload.wr   = wr_en && (paddr[2] == REG_INITIAL);
  assign reload.kbps = pwdata[KBPS_W-1:0];

  always_comb begin
    unique case (paddr[2])
      REG_MODE:    prdata = {30'd0, mode};
      REG_INITIAL: prdata = {14'd0, initial_kbps};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    unique case (mode)
      MODE_QUALITY: begin
        lo_wide = {2'b0, initial_kbps[KBPS_W-1:1]};
        hi_wide = kbps_wide_t'(({2'b0, initial_kbps, 1'b0} + {3'b0, initial_kbps}) >> 1);
        if (lo_wide < {1'b0, MIN_QUALITY}) lo_wide = {1'b0, MIN_QUALITY};
        if (hi_wide > {1'b0, BITRATE_CAP}) hi_wide = {1'b0, BITRATE_CAP};
      end
      MODE_LOW_LATENCY: begin
        lo_wide = {1'b0, MIN_LOW_LAT};
        hi_wide = scale(initial_kbps, RECIP_6_5);
      end
      default: begin
        lo_wide = scale(initial_kbps, RECIP_3_10);
        hi_wide = {initial_kbps, 1'b0};
        if (lo_wide < {1'b0, MIN_BALANCED}) lo_wide = {1'b0, MIN_BALANCED};
        if (hi_wide > {1'b0, BITRATE_CAP}) hi_wide = {1'b0, BITRATE_CAP};
      end
    endcase
    limits_next.lo = lo_wide[KBPS_W-1:0];
    limits_next.hi = (hi_wide > {1'b0, KBPS_MAX}) ? KBPS_MAX : hi_wide[KBPS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= '{lo: LO_RST, hi: HI_RST};
    end else begin
      limits <= limits_next;
    end
  end

endmodule

FILE: sv/lbc_step.sv
module lbc_step (
  input  lbc_pkg::ms_t     now_ms,
  input  lbc_pkg::loss_t   loss_pct_q8,
  input  logic [1:0]       mode,
  input  lbc_pkg::limits_t limits,
  input  lbc_pkg::state_t  state,
  output lbc_pkg::state_t  state_next,
  output lbc_pkg::result_t result
);
  import lbc_pkg::*;

  ms_t        elapsed;
  ms_t        cooldown;
  logic       cooling;
  cnt_t       run_inc;
  cnt_t       stable_inc;
  cnt_t       stable_need;
  logic       apply;
  recip_t     recip;
  kbps_wide_t target;
  kbps_t      clamped;

  assign elapsed     = now_ms - state.last_change;
  assign cooldown    = (mode == MODE_LOW_LATENCY) ? COOLDOWN_LOW_LAT : COOLDOWN_DEFAULT;
  assign cooling     = elapsed < cooldown;
  assign run_inc     = sat_inc(state.loss_run);
  assign stable_inc  = sat_inc(state.stable);
  assign stable_need = (mode == MODE_QUALITY) ? STABLE_QUALITY : STABLE_DEFAULT;

  always_comb begin
    apply               = 1'b0;
    recip               = RECIP_7_10;
    state_next          = state;
    if (loss_pct_q8 > LOSS_HEAVY) begin
      apply               = 1'b1;
      state_next.stable   = '0;
      state_next.loss_run = run_inc;
    end else if (loss_pct_q8 > LOSS_MEDIUM) begin
      state_next.loss_run = run_inc;
      if (run_inc >= RUN_MEDIUM) begin
        apply             = 1'b1;
        recip             = RECIP_9_10;
        state_next.stable = '0;
      end
    end else if (loss_pct_q8 > LOSS_LIGHT) begin
      state_next.loss_run = run_inc;
      state_next.stable   = '0;
      if (run_inc >= RUN_LIGHT) begin
        apply = 1'b1;
        recip = RECIP_19_20;
      end
    end else begin
      // clean tick: probe upward once the stable streak is long enough
      state_next.loss_run = '0;
      state_next.stable   = stable_inc;
      if (stable_inc >= stable_need && state.current < limits.hi) begin
        apply             = 1'b1;
        recip             = RECIP_21_20;
        state_next.stable = '0;
      end
    end

    target = apply ? scale(state.current, recip) : {1'b0, state.current};
    // minimum first, then maximum, so the maximum prevails
    if (target < {1'b0, limits.lo}) target = {1'b0, limits.lo};
    clamped = (target > {1'b0, limits.hi}) ? limits.hi : target[KBPS_W-1:0];

    state_next.current     = clamped;
    state_next.last_change = (clamped != state.current) ? now_ms : state.last_change;
    result.bitrate         = clamped;
    result.changed         = clamped != state.current;
    result.in_cooldown     = 1'b0;

    // inside the cooldown window: hold everything
    if (cooling) begin
      state_next         = state;
      result.bitrate     = state.current;
      result.changed     = 1'b0;
      result.in_cooldown = 1'b1;
    end
  end

endmodule

FILE: sv/loss_driven_bitrate_controller_top.sv
// Loss-driven bitrate controller.
// Input channel (in_valid / in_stall) carries one tick: now_ms and
// loss_pct_q8. Output channel (out_valid / out_stall) returns one item per
// tick: bitrate_kbps, changed and in_cooldown, in tick order.
// An APB-style port holds mode (address 0) and initial_kbps (address 4);
// writing initial_kbps also reloads the running bitrate. Write only while
// no tick is in flight.
// A tick is captured in the input register and its result is captured in
// the result register. Throughput: one tick per cycle unless out_stall
// holds a valid result; the bitrate, counters and last-change time are
// updated by one registered pass (one 18x23 reciprocal multiply plus
// clamp) between the input register and the result register.
// Reset (synchronous, rst high) empties both stages, restores the register
// defaults (balanced, 20000 kbps) and clears the counters and the
// last-change time. The min/max limits have their own register after mode.
// When out_stall is high the result holds; if the input register is empty,
// it takes one more tick, then in_stall rises until the result is taken.
module loss_driven_bitrate_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  lbc_pkg::ms_t        now_ms,
  input  lbc_pkg::loss_t      loss_pct_q8,
  output logic                out_valid,
  input  logic                out_stall,
  output lbc_pkg::kbps_t      bitrate_kbps,
  output logic                changed,
  output logic                in_cooldown
);
  import lbc_pkg::*;

  logic    [1:0] mode;
  limits_t limits;
  reload_t reload;

  logic    s1_valid;
  ms_t     s1_now;
  loss_t   s1_loss;
  logic    advance;
  logic    fire;
  state_t  state;
  state_t  state_next;
  result_t result_next;
  result_t result;

  lbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode),
    .limits  (limits),
    .reload  (reload)
  );

  lbc_step u_step (
    .now_ms      (s1_now),
    .loss_pct_q8 (s1_loss),
    .mode        (mode),
    .limits      (limits),
    .state       (state),
    .state_next  (state_next),
    .result      (result_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  // load whenever the input register is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now  <= now_ms;
      s1_loss <= loss_pct_q8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{current: INITIAL_RST, last_change: '0, stable: '0, loss_run: '0};
    end else if (reload.wr) begin
      state.current <= reload.kbps;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign bitrate_kbps = result.bitrate;
  assign changed      = result.changed;
  assign in_cooldown  = result.in_cooldown;

endmodule

FILE: sv/lbc_checker.sv
module lbc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lbc_pkg::kbps_t bitrate_kbps,
  input logic           changed,
  input logic           in_cooldown
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bitrate_kbps)
      && $stable(changed) && $stable(in_cooldown))
    else $error("stalled result changed");

  a_cooldown_no_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_cooldown |-> !changed)
    else $error("item flagged both cooldown and changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result stage empty");

endmodule

bind loss_driven_bitrate_controller_top lbc_checker u_lbc_checker (.*);

FILE: bench/tb_loss_driven_bitrate_controller_top.sv
`timescale 1ns / 1ps

module tb_loss_driven_bitrate_controller_top;
  import lbc_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 75;
  localparam int PRESSURE_ITEMS = 30;
  localparam int PRINT_LIMIT    = 200;

  // Tracks the controller's rate and counters and queues the result each tick should give.
  class rate_tracker;
    logic [1:0]  cfg_mode;
    kbps_t       base_kbps;
    kbps_t       rate_kbps;
    ms_t         last_change;
    cnt_t        stable_cnt;
    cnt_t        lossy_run;
    result_t     expected_rates[$];
    int unsigned errors;

    function new();
      cfg_mode    = MODE_BALANCED;
      base_kbps   = INITIAL_RST;
      rate_kbps   = INITIAL_RST;
      last_change = '0;
      stable_cnt  = '0;
      lossy_run   = '0;
      errors      = 0;
    endfunction

    function void set_base(kbps_t k);
      base_kbps = k;
      rate_kbps = k;
    endfunction

    function int unsigned pending();
      return expected_rates.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    endtask

    function cnt_t bump(cnt_t c);
      return (c == CNT_MAX) ? c : c + 8'd1;
    endfunction

    function void note_tick(ms_t now, loss_t loss);
      longint unsigned lo, hi, cur, tgt, base;
      ms_t     elapsed, hold_ms;
      cnt_t    need;
      result_t r;
      elapsed = now - last_change;
      hold_ms = (cfg_mode == MODE_LOW_LATENCY) ? COOLDOWN_LOW_LAT : COOLDOWN_DEFAULT;
      r.bitrate     = rate_kbps;
      r.changed     = 1'b0;
      r.in_cooldown = 1'b0;
      // ignore the tick entirely while the last change is still fresh
      if (elapsed < hold_ms) begin
        r.in_cooldown = 1'b1;
        expected_rates.push_back(r);
        return;
      end
      base = base_kbps;
      cur  = rate_kbps;
      tgt  = cur;
      case (cfg_mode)
        MODE_QUALITY: begin
          lo = base / 2;
          if (lo < MIN_QUALITY) lo = MIN_QUALITY;
          hi = base * 3 / 2;
          if (hi > BITRATE_CAP) hi = BITRATE_CAP;
        end
        MODE_LOW_LATENCY: begin
          lo = MIN_LOW_LAT;
          hi = base * 6 / 5;
        end
        default: begin
          lo = base * 3 / 10;
          if (lo < MIN_BALANCED) lo = MIN_BALANCED;
          hi = base * 2;
          if (hi > BITRATE_CAP) hi = BITRATE_CAP;
        end
      endcase
      if (hi > KBPS_MAX) hi = KBPS_MAX;
      if (lo > KBPS_MAX) lo = KBPS_MAX;
      need = (cfg_mode == MODE_QUALITY) ? STABLE_QUALITY : STABLE_DEFAULT;

      if (loss > LOSS_HEAVY) begin
        tgt        = cur * 7 / 10;
        stable_cnt = '0;
        lossy_run  = bump(lossy_run);
      end else if (loss > LOSS_MEDIUM) begin
        lossy_run = bump(lossy_run);
        if (lossy_run >= RUN_MEDIUM) begin
          tgt        = cur * 9 / 10;
          stable_cnt = '0;
        end
      end else if (loss > LOSS_LIGHT) begin
        lossy_run  = bump(lossy_run);
        stable_cnt = '0;
        if (lossy_run >= RUN_LIGHT) tgt = cur * 19 / 20;
      end else begin
        lossy_run  = '0;
        stable_cnt = bump(stable_cnt);
        if (stable_cnt >= need && cur < hi) begin
          tgt        = cur * 21 / 20;
          stable_cnt = '0;
        end
      end

      // minimum first, so the maximum has the last word
      if (tgt < lo) tgt = lo;
      if (tgt > hi) tgt = hi;
      if (tgt != cur) begin
        rate_kbps   = tgt[KBPS_W-1:0];
        last_change = now;
        r.changed   = 1'b1;
      end
      r.bitrate = rate_kbps;
      expected_rates.push_back(r);
    endfunction

    task check_result(kbps_t kbps, logic chg, logic cool);
      result_t e;
      if (expected_rates.size() == 0) begin
        report($sformatf("result with none outstanding, bitrate %0d", kbps));
        return;
      end
      e = expected_rates.pop_front();
      if (kbps !== e.bitrate)
        report($sformatf("bitrate_kbps %0d, want %0d", kbps, e.bitrate));
      if (chg !== e.changed)
        report($sformatf("changed %b, want %b", chg, e.changed));
      if (cool !== e.in_cooldown)
        report($sformatf("in_cooldown %b, want %b", cool, e.in_cooldown));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  ms_t         now_ms;
  loss_t       loss_pct_q8;
  logic        out_valid;
  logic        out_stall;
  kbps_t       bitrate_kbps;
  logic        changed;
  logic        in_cooldown;

  rate_tracker book;
  bit          hold_req;
  bit          gaps_on;
  ms_t         clock_ms;
  int          streak_left;
  int          burst_left;
  loss_t       streak_lo, streak_hi;

  loss_driven_bitrate_controller_top uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .loss_pct_q8  (loss_pct_q8),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bitrate_kbps (bitrate_kbps),
    .changed      (changed),
    .in_cooldown  (in_cooldown)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: a random 32-bit stall pattern, re-drawn once all its bits are used, or a long hold on request.
  initial begin : receiver
    logic [31:0] stall_pat;
    logic [4:0]  slot;
    stall_pat = '0;
    slot      = '0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (slot == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '0;
            1: stall_pat = $urandom & $urandom;
            2: stall_pat = $urandom;
            default: stall_pat = $urandom & $urandom & $urandom;
          endcase
        end
        out_stall <= stall_pat[slot];
        slot++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_result(bitrate_kbps, changed, in_cooldown);
  end

  task automatic send_tick(input ms_t t, input loss_t l);
    in_valid    <= 1'b1;
    now_ms      <= t;
    loss_pct_q8 <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_tick(t, l);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODE) book.cfg_mode = data[1:0];
    else book.set_base(data[KBPS_W-1:0]);
    @(posedge clk);
  endtask

  task automatic reg_check(input logic idx);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_MODE) ? 32'(book.cfg_mode) : 32'(book.base_kbps);
    if (prdata !== want)
      book.report($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input kbps_t k, input bit write_base);
    logic [31:0] data;
    drain();
    repeat (4) @(posedge clk);
    // junk in the unused upper bits now and then; it must be masked off
    data = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
    data[1:0] = m;
    reg_write(REG_MODE, data);
    if (write_base) begin
      data = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
      data[KBPS_W-1:0] = k;
      reg_write(REG_INITIAL, data);
    end
    reg_check(REG_MODE);
    reg_check(REG_INITIAL);
    repeat (2) @(posedge clk);
  endtask

  // Mostly steps that clear the cooldown, with loss mostly arriving in streaks of one class.
  task automatic random_tick();
    int unsigned pick;
    loss_t       l;
    pick = $urandom_range(0, 99);
    if (pick < 60)      clock_ms += $urandom_range(2000, 2600);
    else if (pick < 80) clock_ms += $urandom_range(1400, 2100);
    else if (pick < 92) clock_ms += $urandom_range(0, 1400);
    else                clock_ms = $urandom;
    if (streak_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        streak_lo = '0;
        streak_hi = LOSS_LIGHT;
      end else if (pick < 6) begin
        streak_lo = LOSS_LIGHT + 15'd1;
        streak_hi = LOSS_MEDIUM;
      end else if (pick < 8) begin
        streak_lo = LOSS_MEDIUM + 15'd1;
        streak_hi = LOSS_HEAVY;
      end else if (pick < 9) begin
        streak_lo = LOSS_HEAVY + 15'd1;
        streak_hi = 15'd25600;
      end else begin
        streak_lo = '0;
        streak_hi = 15'h7FFF;
      end
      // long streaks drive the counters into saturation
      streak_left = ($urandom_range(0, 24) == 0) ? 300 : $urandom_range(1, 8);
    end
    streak_left--;
    l = loss_t'($urandom_range(streak_lo, streak_hi));
    if (burst_left == 0) begin
      if (gaps_on) pause($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_tick(clock_ms, l);
  endtask

  initial begin : stimulus
    ms_t        t;
    int         p, i;
    logic [1:0] m;
    kbps_t      k;
    bit         wb;
    book        = new();
    hold_req    = 1'b0;
    gaps_on     = 1'b0;
    streak_left = 0;
    burst_left  = 0;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    now_ms      <= '0;
    loss_pct_q8 <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_check(REG_MODE);
    reg_check(REG_INITIAL);

    // Walk the loss classes from reset defaults, hitting each threshold.
    send_tick(32'd0, 15'd0);
    send_tick(32'd1999, 15'h7FFF);
    t = 32'd2000;
    send_tick(t, LOSS_LIGHT);
    t += 2500; send_tick(t, LOSS_LIGHT + 15'd1);
    t += 2500; send_tick(t, LOSS_MEDIUM);
    t += 2500; send_tick(t, LOSS_MEDIUM + 15'd1);
    t += 1000; send_tick(t, LOSS_HEAVY + 15'd1);
    t += 1000; send_tick(t, LOSS_HEAVY);
    t += 2000; send_tick(t, LOSS_HEAVY + 15'd1);
    t += 2000; send_tick(t, 15'h7FFF);
    t += 2000; send_tick(t, 15'd200);
    repeat (5) begin
      t += 2000;
      send_tick(t, 15'd0);
    end
    repeat (4) begin
      t += 2000;
      send_tick(t, 15'd25600);
    end
    // timestamp wrap
    send_tick(32'hFFFF_F000, 15'd0);
    send_tick(32'h0000_0100, 15'd0);
    clock_ms = 32'h0000_0100;

    for (p = 0; p < PHASES; p++) begin
      wb = 1'b1;
      case (p)
        0: begin m = MODE_QUALITY;     k = 18'd500;    end
        1: begin m = MODE_LOW_LATENCY; k = 18'd150000; end
        2: begin m = MODE_SPARE;       k = KBPS_MAX;   end
        3: begin m = MODE_BALANCED;    k = 18'd0;      end
        4: begin m = MODE_LOW_LATENCY; k = 18'd0;      end
        5: begin m = MODE_QUALITY;     k = 18'd150000; end
        6: begin m = MODE_BALANCED;    k = 18'd500;    end
        7: begin m = MODE_LOW_LATENCY; k = KBPS_MAX;   end
        default: begin
          m  = 2'($urandom_range(0, 3));
          wb = ($urandom_range(0, 3) != 0);
          case ($urandom_range(0, 9))
            0: k = kbps_t'($urandom_range(0, 499));
            1: k = kbps_t'($urandom_range(150001, 262143));
            default: k = kbps_t'($urandom_range(500, 150000));
          endcase
        end
      endcase
      configure(m, k, wb);
      gaps_on = (p % 3 != 0);
      if (p == 1) begin
        // receiver holds off while items keep coming, so the input backs up
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) random_tick();
        gaps_on  = 1'b1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p % 2 == 1) drain();
        random_tick();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
